// ===== hw/rtl/ctp_pkg.sv =====
// ----------------------------------------------------------------------------
// ctp_pkg: shared definitions for the countdown timer pool
// Pool size, field widths, action and status codes, controller state and the
// command and status bundles that join the controller to the datapath.
// ----------------------------------------------------------------------------
package ctp_pkg;

   // pool size and derived index width
   localparam int NUM_TIMERS  = 8;
   localparam int TIMER_IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

   // field widths
   localparam int ACTION_W = 3;
   localparam int INDEX_W  = 8;
   localparam int COUNT_W  = 32;
   localparam int STATUS_W = 2;

   // stream word widths, padded to whole bytes
   localparam int REQ_BITS   = ACTION_W + INDEX_W + COUNT_W;
   localparam int RSP_BITS   = STATUS_W + INDEX_W + COUNT_W;
   localparam int REQ_DATA_W = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((RSP_BITS + 7) / 8) * 8;

   // action codes
   localparam logic [ACTION_W-1:0] ACT_TICK    = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_ALLOC   = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_RELEASE = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_LOAD    = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_READ    = 3'd4;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NO_FREE   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd2;
   localparam logic [STATUS_W-1:0] ST_NOT_ALLOC = 2'd3;

   // controller states
   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_TICK,
      S_ALLOC,
      S_EXEC,
      S_DONE
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic capture;     // latch the request word, clear the pointer
      logic step_ptr;    // advance the scan pointer
      logic tick_write;  // decrement the timer under the pointer
      logic alloc_take;  // claim the timer under the pointer
      logic exec_single; // run release, load or read on the addressed timer
      logic publish;     // move the result into the output register
   } ctp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [ACTION_W-1:0] action;   // captured action code
      logic                ptr_last; // pointer at the last timer
      logic                ptr_free; // timer under the pointer is free
      logic                out_busy; // output word held and not taken
   } ctp_stat_type;

endpackage

// ===== hw/rtl/ctp_ctrl.sv =====
// ----------------------------------------------------------------------------
// ctp_ctrl: sequencer for the countdown timer pool
// Accepts one request word at a time, walks the datapath through the tick
// scan, the allocate search or a single access, then hands off the result.
// ----------------------------------------------------------------------------
module ctp_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   output ctp_pkg::ctp_cmd_type  cmd,
   input  ctp_pkg::ctp_stat_type stat
);
   import ctp_pkg::*;

   state_type state_ff;
   state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            if (stat.action == ACT_TICK) begin
               state_in = S_TICK;
            end else if (stat.action == ACT_ALLOC) begin
               state_in = S_ALLOC;
            end else begin
               state_in = S_EXEC;
            end
         end
         S_TICK: begin
            if (stat.ptr_last) begin
               state_in = S_DONE;
            end
         end
         S_ALLOC: begin
            if (stat.ptr_free || stat.ptr_last) begin
               state_in = S_DONE;
            end
         end
         S_EXEC: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!stat.out_busy) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // command outputs
   always_comb begin
      req_tready = 1'b0;
      cmd        = '0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
         end
         S_DECODE: begin
         end
         S_TICK: begin
            cmd.tick_write = 1'b1;
            cmd.step_ptr   = 1'b1;
         end
         S_ALLOC: begin
            cmd.alloc_take = stat.ptr_free;
            cmd.step_ptr   = !stat.ptr_free;
         end
         S_EXEC: begin
            cmd.exec_single = 1'b1;
         end
         S_DONE: begin
            cmd.publish = !stat.out_busy;
         end
         default: begin
         end
      endcase
   end

   // a result never overwrites a word still waiting on the output
   a_publish_free: assert property (@(posedge clock) disable iff (reset)
      cmd.publish |-> !stat.out_busy)
      else $error("result published over a held output word");

   // a new word is taken only with no item in flight
   a_capture_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> state_ff == S_DECODE)
      else $error("capture did not start decode");

   // allocate claims at most once per item
   a_alloc_once: assert property (@(posedge clock) disable iff (reset)
      cmd.alloc_take |=> !cmd.alloc_take)
      else $error("two timers claimed by one allocate");

endmodule

// ===== hw/rtl/ctp_datapath.sv =====
// ----------------------------------------------------------------------------
// ctp_datapath: timer state, shared decrementer and result registers
// Holds the free flags and counts, a scan pointer that shares the single count
// port with the request index, the working result and the output register.
// ----------------------------------------------------------------------------
module ctp_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [ctp_pkg::REQ_DATA_W-1:0]      req_tdata,
   input  ctp_pkg::ctp_cmd_type                cmd,
   output ctp_pkg::ctp_stat_type               stat,
   input  logic                                rsp_tready,
   output logic                                rsp_tvalid,
   output logic [ctp_pkg::RSP_DATA_W-1:0]      rsp_tdata
);
   import ctp_pkg::*;

   // timer state
   logic [NUM_TIMERS-1:0] free_ff;
   logic [NUM_TIMERS-1:0] free_in;
   logic [COUNT_W-1:0]    count_ff [NUM_TIMERS];

   // captured request word
   logic [ACTION_W-1:0] act_ff;
   logic [INDEX_W-1:0]  idx_ff;
   logic [COUNT_W-1:0]  value_ff;

   // scan pointer
   logic [TIMER_IDX_W-1:0] ptr_ff;
   logic [TIMER_IDX_W-1:0] ptr_in;

   // working result
   logic [STATUS_W-1:0] res_status_ff;
   logic [STATUS_W-1:0] res_status_in;
   logic [INDEX_W-1:0]  res_handle_ff;
   logic [INDEX_W-1:0]  res_handle_in;
   logic [COUNT_W-1:0]  res_count_ff;
   logic [COUNT_W-1:0]  res_count_in;

   // output register
   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] out_status_ff;
   logic [INDEX_W-1:0]  out_handle_ff;
   logic [COUNT_W-1:0]  out_count_ff;

   // count access port
   logic [TIMER_IDX_W-1:0] acc_idx;
   logic [COUNT_W-1:0]     acc_rdata;
   logic                   acc_free;
   logic                   in_range;
   logic                   cnt_we;
   logic [COUNT_W-1:0]     cnt_wdata;

   // select the timer under access
   always_comb begin
      acc_idx   = cmd.exec_single ? idx_ff[TIMER_IDX_W-1:0] : ptr_ff;
      acc_rdata = count_ff[acc_idx];
      acc_free  = free_ff[acc_idx];
      in_range  = ({1'b0, idx_ff} < (INDEX_W + 1)'(NUM_TIMERS));
   end

   // decide state updates and the result
   always_comb begin
      free_in       = free_ff;
      cnt_we        = 1'b0;
      cnt_wdata     = acc_rdata;
      ptr_in        = ptr_ff;
      res_status_in = res_status_ff;
      res_handle_in = res_handle_ff;
      res_count_in  = res_count_ff;

      if (cmd.capture) begin
         ptr_in        = '0;
         res_status_in = (req_tdata[ACTION_W-1:0] == ACT_ALLOC) ? ST_NO_FREE : ST_OK;
         res_handle_in = '0;
         res_count_in  = '0;
      end
      if (cmd.step_ptr) begin
         ptr_in = ptr_ff + 1'b1;
      end

      // decrement an allocated, nonzero timer
      if (cmd.tick_write && !acc_free && (acc_rdata != '0)) begin
         cnt_we    = 1'b1;
         cnt_wdata = acc_rdata - 1'b1;
      end

      // claim the first free timer found
      if (cmd.alloc_take) begin
         free_in[acc_idx] = 1'b0;
         res_status_in    = ST_OK;
         res_handle_in    = INDEX_W'(ptr_ff);
      end

      // single addressed access
      if (cmd.exec_single) begin
         case (act_ff)
            ACT_RELEASE: begin
               if (!in_range) begin
                  res_status_in = ST_RANGE;
               end else begin
                  free_in[acc_idx] = 1'b1;
               end
            end
            ACT_LOAD: begin
               if (!in_range) begin
                  res_status_in = ST_RANGE;
               end else if (acc_free) begin
                  res_status_in = ST_NOT_ALLOC;
               end else begin
                  cnt_we    = 1'b1;
                  cnt_wdata = value_ff;
               end
            end
            ACT_READ: begin
               if (!in_range) begin
                  res_status_in = ST_RANGE;
               end else begin
                  res_count_in = acc_rdata;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // timer state and output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         free_ff      <= '1;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < NUM_TIMERS; k++) begin
            count_ff[k] <= '0;
         end
      end else begin
         free_ff <= free_in;
         if (cnt_we) begin
            count_ff[acc_idx] <= cnt_wdata;
         end
         if (cmd.publish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         act_ff   <= req_tdata[ACTION_W-1:0];
         idx_ff   <= req_tdata[ACTION_W +: INDEX_W];
         value_ff <= req_tdata[ACTION_W + INDEX_W +: COUNT_W];
      end
      ptr_ff        <= ptr_in;
      res_status_ff <= res_status_in;
      res_handle_ff <= res_handle_in;
      res_count_ff  <= res_count_in;
      if (cmd.publish) begin
         out_status_ff <= res_status_ff;
         out_handle_ff <= res_handle_ff;
         out_count_ff  <= res_count_ff;
      end
   end

   // status back to the controller
   always_comb begin
      stat.action   = act_ff;
      stat.ptr_last = (ptr_ff == TIMER_IDX_W'(NUM_TIMERS - 1));
      stat.ptr_free = free_ff[ptr_ff];
      stat.out_busy = rsp_valid_ff && !rsp_tready;
   end

   // drive the result word
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_DATA_W - RSP_BITS)'(0), out_count_ff, out_handle_ff,
                        out_status_ff};

   // a claimed timer reads as allocated afterward
   a_alloc_claims: assert property (@(posedge clock) disable iff (reset)
      cmd.alloc_take |=> !free_ff[$past(ptr_ff)])
      else $error("allocate left the timer free");

   // an exhausted pool really has no free timer
   a_no_free_true: assert property (@(posedge clock) disable iff (reset)
      (cmd.publish && act_ff == ACT_ALLOC && res_status_ff == ST_NO_FREE)
      |-> free_ff == '0)
      else $error("no free timer reported while one is free");

   // the tick scan never touches the free flags
   a_tick_flags: assert property (@(posedge clock) disable iff (reset)
      cmd.tick_write |=> $stable(free_ff))
      else $error("free flags changed during tick");

   // the output word appears only after a publish
   a_valid_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.publish))
      else $error("output valid without publish");

endmodule

// ===== hw/rtl/countdown_timer_pool.sv =====
// ----------------------------------------------------------------------------
// countdown_timer_pool: pool of countdown timers with a request stream
// Each request word carries tick, allocate, release, load or read and gives
// exactly one response word with a status, a handle and a count.
// ----------------------------------------------------------------------------
//
//   channel   dir   handshake             payload
//   req       in    req_tvalid/tready     action, timer_index, load_value
//   rsp       out   rsp_tvalid/tready     status, handle, count_value
//
// One request is in flight at a time. Release, load, read and unused codes
// pass through decode and a single access before the result; a tick walks
// all NUM_TIMERS counts with one shared decrementer, one timer per cycle;
// allocate runs the same walk, stopping at the first free timer.
// The output register lets the next request be accepted while a response
// waits; a stalled response holds the sequencer only at its hand-off.
// Reset is synchronous and frees every timer with a zero count.
module countdown_timer_pool (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // [2:0] action, [10:3] timer_index, [42:11] load_value, [47:43] zero
   input  logic [ctp_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // [1:0] status, [9:2] handle, [41:10] count_value, [47:42] zero
   output logic [ctp_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import ctp_pkg::*;

   ctp_cmd_type  cmd;
   ctp_stat_type stat;

   // sequencer
   ctp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .cmd        (cmd),
      .stat       (stat)
   );

   // timer state and result path
   ctp_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
